FILE: src/lge_pkg.sv
// ----------------------------------------------------------------------------
// lge_pkg - shared definitions for the Life grid engine
// Default sizes, operation codes, register indexes and the column window type.
// ----------------------------------------------------------------------------
package lge_pkg;

  localparam int GRID_COLS_DEF     = 64;
  localparam int GRID_ROWS_DEF     = 64;
  localparam int HISTORY_DEPTH_DEF = 10;

  // Operation codes
  localparam logic [2:0] OP_STEP     = 3'd0;
  localparam logic [2:0] OP_WRITE    = 3'd1;
  localparam logic [2:0] OP_CLEAR    = 3'd2;
  localparam logic [2:0] OP_ROLLBACK = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ACTIVE_COLS = 2'd0;
  localparam logic [1:0] REG_ACTIVE_ROWS = 2'd1;
  localparam logic [1:0] REG_EDIT_ENABLE = 2'd2;

  localparam logic [6:0] ACTIVE_SIZE_RST = 7'd64;

  // Three vertically adjacent cells of one column: row above, row, row below
  typedef struct packed {
    logic up;
    logic mid;
    logic dn;
  } win_t;

endpackage

FILE: src/lge_cell.sv
// ----------------------------------------------------------------------------
// lge_cell - one column cell of the generation chain
// Holds two rows of its column, takes a new row each shift_i cycle, shows its
// window to both neighbors; computes the B3/S23 next state of the middle row.
// ----------------------------------------------------------------------------
module lge_cell (
  input  logic          clk_i,
  input  logic          clr_i,
  input  logic          shift_i,
  input  logic          dn_i,
  input  lge_pkg::win_t left_i,
  input  lge_pkg::win_t right_i,
  output lge_pkg::win_t win_o,
  output logic          next_o
);

  logic       up_q, mid_q;
  logic [3:0] nbrs;

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      up_q  <= 1'b0;
      mid_q <= 1'b0;
    end else if (shift_i) begin
      up_q  <= mid_q;
      mid_q <= dn_i;
    end
  end

  assign win_o = '{up: up_q, mid: mid_q, dn: dn_i};

  assign nbrs = 4'(left_i.up) + 4'(left_i.mid) + 4'(left_i.dn)
              + 4'(right_i.up) + 4'(right_i.mid) + 4'(right_i.dn)
              + 4'(up_q) + 4'(dn_i);

  // Birth on three, survival on two or three
  assign next_o = (nbrs == 4'd3) || (mid_q && (nbrs == 4'd2));

endmodule

FILE: src/lge_frame_mem.sv
// ----------------------------------------------------------------------------
// lge_frame_mem - frame history storage
// One row per word, one write port with a per-bit mask, one registered read.
// ----------------------------------------------------------------------------
module lge_frame_mem #(
  parameter int Depth = 640,
  parameter int Width = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wmask_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int i = 0; i < Width; i++) begin
        if (wmask_i[i]) begin
          mem_q[waddr_i][i] <= wdata_i[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/life_grid_engine_with_history_core.sv
// ----------------------------------------------------------------------------
// life_grid_engine_with_history_core - B3/S23 Life engine with frame history
// Command-driven Life grid with a ring of frames, rollback and cell access.
// ----------------------------------------------------------------------------
// Issue a command by raising start while busy is low; the command is taken at
// that clock edge. After reset the engine sweeps the whole frame store to dead
// cells (HISTORY_DEPTH*GRID_ROWS rows, 640 with the defaults), one row per
// cycle, and holds busy high meanwhile; configuration writes are taken at
// any time. A step reads the current frame one row per cycle from the frame
// memory and pushes each row through a chain of GRID_COLS column cells, which
// write the next generation into the oldest frame one row behind; busy stays
// high until the last row is written. Clear writes one empty frame. A read
// holds busy for one cycle, and its result appears in the cycle after on
// read_value_o/outside_grid_o with result_valid_o high for exactly
// that one cycle; the receiver cannot stall it, so capture it then. Cell
// writes, rollback and unknown opcodes finish at the accepting edge and keep
// busy low. Reads and writes address the current frame; a cell write is
// dropped unless edit_enable is set and the address lies inside the active
// area. Change the configuration only while the engine is idle.
// ----------------------------------------------------------------------------
module life_grid_engine_with_history_core #(
  parameter int GRID_COLS     = lge_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS     = lge_pkg::GRID_ROWS_DEF,
  parameter int HISTORY_DEPTH = lge_pkg::HISTORY_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command transaction
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode_i,
  input  logic [5:0]  cell_col_i,
  input  logic [5:0]  cell_row_i,
  input  logic        write_value_i,
  // result transaction
  output logic        result_valid_o,
  output logic        read_value_o,
  output logic        outside_grid_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int MemDepth = HISTORY_DEPTH * GRID_ROWS;
  localparam int AddrW    = $clog2(MemDepth);
  localparam int FrameW   = $clog2(HISTORY_DEPTH);
  localparam int RowW     = $clog2(GRID_ROWS);
  localparam int ColW     = $clog2(GRID_COLS);
  localparam int CntW     = $clog2(GRID_ROWS + 2);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_STEP,
    S_CLEAR,
    S_READ
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [6:0] active_cols_q, active_rows_q;
  logic       edit_enable_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_cols_q <= lge_pkg::ACTIVE_SIZE_RST;
      active_rows_q <= lge_pkg::ACTIVE_SIZE_RST;
      edit_enable_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        lge_pkg::REG_ACTIVE_COLS: active_cols_q <= pwdata[6:0];
        lge_pkg::REG_ACTIVE_ROWS: active_rows_q <= pwdata[6:0];
        lge_pkg::REG_EDIT_ENABLE: edit_enable_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lge_pkg::REG_ACTIVE_COLS: prdata = {25'd0, active_cols_q};
      lge_pkg::REG_ACTIVE_ROWS: prdata = {25'd0, active_rows_q};
      lge_pkg::REG_EDIT_ENABLE: prdata = {31'd0, edit_enable_q};
      default:                  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  state_e            state_q;
  logic [FrameW-1:0] cur_q;
  logic [FrameW-1:0] dst;
  logic [CntW-1:0]   cnt_q;
  logic [AddrW-1:0]  init_q;
  logic              inside_q;
  logic [ColW-1:0]   col_q;
  logic              result_valid_q, read_value_q, outside_q;

  logic              accept;
  logic              in_area;
  logic [ColW-1:0]   col_idx;
  logic              feed_ok, row_ok;

  // memory ports
  logic                 mem_we;
  logic [AddrW-1:0]     mem_waddr, mem_raddr;
  logic [GRID_COLS-1:0] mem_wmask, mem_wdata, mem_rdata;

  // cell chain
  logic [GRID_COLS-1:0] col_en, next_row, feed_row;
  lge_pkg::win_t        win [GRID_COLS];
  logic                 chain_clr, chain_shift;

  function automatic logic [AddrW-1:0] row_addr(input logic [FrameW-1:0] f,
                                                input logic [RowW-1:0]   r);
    row_addr = AddrW'(int'(f) * GRID_ROWS) + AddrW'(r);
  endfunction

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign col_idx = ColW'(cell_col_i);

  assign in_area = (int'(cell_col_i) < int'(active_cols_q)) && (int'(cell_col_i) < GRID_COLS)
                && (int'(cell_row_i) < int'(active_rows_q)) && (int'(cell_row_i) < GRID_ROWS);

  // advance round the ring
  assign dst = (int'(cur_q) == HISTORY_DEPTH - 1) ? '0 : cur_q + FrameW'(1);

  // Row cnt-1 enters the chain at count cnt; row cnt-2 leaves it
  assign feed_ok = (cnt_q != '0) && (int'(cnt_q) - 1 < GRID_ROWS)
                && (int'(cnt_q) - 1 < int'(active_rows_q));
  assign row_ok  = (int'(cnt_q) >= 2) && (int'(cnt_q) - 2 < int'(active_rows_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_INIT;
      cur_q          <= '0;
      cnt_q          <= '0;
      init_q         <= '0;
      inside_q       <= 1'b0;
      col_q          <= '0;
      result_valid_q <= 1'b0;
      read_value_q   <= 1'b0;
      outside_q      <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;
      unique case (state_q)
        S_INIT: begin
          init_q <= init_q + AddrW'(1);
          if (int'(init_q) == MemDepth - 1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          cnt_q <= '0;
          if (accept) begin
            unique case (opcode_i)
              lge_pkg::OP_STEP:     state_q <= S_STEP;
              lge_pkg::OP_CLEAR:    state_q <= S_CLEAR;
              lge_pkg::OP_ROLLBACK: cur_q   <= (cur_q == '0) ? FrameW'(HISTORY_DEPTH - 1)
                                                             : cur_q - FrameW'(1);
              lge_pkg::OP_READ: begin
                state_q  <= S_READ;
                inside_q <= in_area;
                col_q    <= col_idx;
              end
              default: ;
            endcase
          end
        end
        S_STEP: begin
          cnt_q <= cnt_q + CntW'(1);
          if (int'(cnt_q) == GRID_ROWS + 1) begin
            cur_q   <= dst;
            state_q <= S_IDLE;
          end
        end
        S_CLEAR: begin
          cnt_q <= cnt_q + CntW'(1);
          if (int'(cnt_q) == GRID_ROWS - 1) begin
            cur_q   <= dst;
            state_q <= S_IDLE;
          end
        end
        S_READ: begin
          result_valid_q <= 1'b1;
          read_value_q   <= inside_q && mem_rdata[col_q];
          outside_q      <= !inside_q;
          state_q        <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = result_valid_q;
  assign read_value_o   = read_value_q;
  assign outside_grid_o = outside_q;

  // --------------------------------------------------------------------------
  // Frame memory access
  // --------------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = init_q;
    mem_wmask = '1;
    mem_wdata = '0;
    mem_raddr = row_addr(cur_q, RowW'(cnt_q));
    unique case (state_q)
      S_INIT: mem_we = 1'b1;
      S_IDLE: begin
        // single cell edit goes straight into the current frame
        mem_we    = accept && (opcode_i == lge_pkg::OP_WRITE) && edit_enable_q && in_area;
        mem_waddr = row_addr(cur_q, RowW'(cell_row_i));
        mem_wmask = GRID_COLS'(1) << col_idx;
        mem_wdata = {GRID_COLS{write_value_i}};
        mem_raddr = row_addr(cur_q, RowW'(cell_row_i));
      end
      S_STEP: begin
        mem_we    = (int'(cnt_q) >= 2);
        mem_waddr = row_addr(dst, RowW'(cnt_q - CntW'(2)));
        mem_wdata = next_row & col_en & {GRID_COLS{row_ok}};
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = row_addr(dst, RowW'(cnt_q));
      end
      default: ;
    endcase
  end

  lge_frame_mem #(
    .Depth (MemDepth),
    .Width (GRID_COLS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wmask_i (mem_wmask),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // --------------------------------------------------------------------------
  // Column cell chain: each cell sees its neighbors' windows; cells outside
  // the active area and rows outside it are fed as dead
  // --------------------------------------------------------------------------
  assign chain_clr   = accept && (opcode_i == lge_pkg::OP_STEP);
  assign chain_shift = (state_q == S_STEP) && (cnt_q != '0);
  assign feed_row    = mem_rdata & col_en & {GRID_COLS{feed_ok}};

  for (genvar i = 0; i < GRID_COLS; i++) begin : g_col
    lge_pkg::win_t left_w, right_w;

    assign col_en[i] = (i < int'(active_cols_q));

    if (i == 0) begin : g_left_edge
      assign left_w = '0;
    end else begin : g_left
      assign left_w = win[i-1];
    end

    if (i == GRID_COLS - 1) begin : g_right_edge
      assign right_w = '0;
    end else begin : g_right
      assign right_w = win[i+1];
    end

    lge_cell u_cell (
      .clk_i   (clk_i),
      .clr_i   (chain_clr),
      .shift_i (chain_shift),
      .dn_i    (feed_row[i]),
      .left_i  (left_w),
      .right_i (right_w),
      .win_o   (win[i]),
      .next_o  (next_row[i])
    );
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_result_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == S_READ))
    else $error("result strobe without a read in progress");

  a_outside_reads_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && outside_grid_o) |-> !read_value_o)
    else $error("live cell reported outside the active area");

  a_frame_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cur_q) < HISTORY_DEPTH)
    else $error("current frame pointer left the ring");

  a_step_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($fell(busy) && $past(state_q == S_STEP)) |-> (cur_q != $past(cur_q)))
    else $error("step finished without moving the current frame");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for the Life grid engine with frame history
// Drives command transactions and APB register writes with random idle bursts.
// Keeps its own copy of the frame ring and predicts every read transaction.
// Directed checks come first: reset state, edit mode, border writes,
// rollback wrap, unused opcodes and empty or oversized areas.
// Random sessions follow, each with new register settings, mostly as
// edit-step-read sequences.
// ----------------------------------------------------------------------------
module tb;

  localparam int NCOLS   = lge_pkg::GRID_COLS_DEF;
  localparam int NROWS   = lge_pkg::GRID_ROWS_DEF;
  localparam int NFRAMES = lge_pkg::HISTORY_DEPTH_DEF;

  // Highest opcode value the field can carry; everything above OP_READ is unused
  localparam logic [2:0] OP_LAST = 3'd7;

  // Longest busy stretch after a command is a step; round up for margin
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS  = 1950;

  // Pending read transactions; at most one is ever outstanding
  localparam int EXP_DEPTH = 16;

  typedef struct packed {
    logic read_value;
    logic outside_grid;
  } cell_readout_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        start         = 1'b0;
  logic        busy;
  logic [2:0]  opcode_i      = lge_pkg::OP_STEP;
  logic [5:0]  cell_col_i    = '0;
  logic [5:0]  cell_row_i    = '0;
  logic        write_value_i = 1'b0;
  logic        result_valid_o;
  logic        read_value_o;
  logic        outside_grid_o;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  life_grid_engine_with_history_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .cell_col_i     (cell_col_i),
    .cell_row_i     (cell_row_i),
    .write_value_i  (write_value_i),
    .result_valid_o (result_valid_o),
    .read_value_o   (read_value_o),
    .outside_grid_o (outside_grid_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // --------------------------------------------------------------------------
  // Shadow state: frame ring (one bit per column in each row word), current
  // frame pointer and register copies
  // --------------------------------------------------------------------------
  bit [NCOLS-1:0] frame_rows [NFRAMES][NROWS];
  int             cur_frame  = 0;
  logic [6:0]     cfg_cols   = lge_pkg::ACTIVE_SIZE_RST;
  logic [6:0]     cfg_rows   = lge_pkg::ACTIVE_SIZE_RST;
  logic           cfg_edit   = 1'b0;

  cell_readout_t  exp_ring [EXP_DEPTH];
  int             exp_wr       = 0;
  int             exp_rd       = 0;
  int             exp_count    = 0;
  int             error_count  = 0;
  int             sent_cmds    = 0;
  bit             gaps_on      = 1'b1;
  bit             start_held   = 1'b0;

  // Clamp a size register to the grid dimension
  function automatic int eff_size(logic [6:0] size, int lim);
    return (int'(size) > lim) ? lim : int'(size);
  endfunction

  // Cells outside the active area read as dead
  function automatic bit live_at(int f, int r, int c, int nr, int nc);
    if (r < 0 || c < 0 || r >= nr || c >= nc) return 1'b0;
    return frame_rows[f][r][c];
  endfunction

  // Compute the next B3/S23 generation of the current frame into the oldest one
  function automatic void advance_generation();
    int src, dst, nr, nc, nbrs;
    bit alive;
    src = cur_frame;
    dst = (cur_frame + 1) % NFRAMES;
    nr  = eff_size(cfg_rows, NROWS);
    nc  = eff_size(cfg_cols, NCOLS);
    for (int r = 0; r < NROWS; r++) frame_rows[dst][r] = '0;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        nbrs = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) nbrs += live_at(src, r + dr, c + dc, nr, nc);
          end
        end
        alive = live_at(src, r, c, nr, nc);
        frame_rows[dst][r][c] = (nbrs == 3) || (alive && nbrs == 2);
      end
    end
    cur_frame = dst;
  endfunction

  // Apply one accepted command to the shadow state; queue the readout of a read
  function automatic void apply_cmd(logic [2:0] op, logic [5:0] col, logic [5:0] row,
                                    logic val);
    bit            in_area;
    int            dst;
    cell_readout_t rd;
    in_area = (int'(col) < eff_size(cfg_cols, NCOLS))
           && (int'(row) < eff_size(cfg_rows, NROWS));
    case (op)
      lge_pkg::OP_STEP: begin
        advance_generation();
      end
      lge_pkg::OP_WRITE: begin
        if (cfg_edit && in_area) frame_rows[cur_frame][row][col] = val;
      end
      lge_pkg::OP_CLEAR: begin
        dst = (cur_frame + 1) % NFRAMES;
        for (int r = 0; r < NROWS; r++) frame_rows[dst][r] = '0;
        cur_frame = dst;
      end
      lge_pkg::OP_ROLLBACK: begin
        cur_frame = (cur_frame + NFRAMES - 1) % NFRAMES;
      end
      lge_pkg::OP_READ: begin
        rd.read_value    = in_area ? frame_rows[cur_frame][row][col] : 1'b0;
        rd.outside_grid  = !in_area;
        exp_ring[exp_wr] = rd;
        exp_wr           = (exp_wr + 1) % EXP_DEPTH;
        exp_count++;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] reg_value(logic [1:0] idx);
    case (idx)
      lge_pkg::REG_ACTIVE_COLS: return {25'd0, cfg_cols};
      lge_pkg::REG_ACTIVE_ROWS: return {25'd0, cfg_rows};
      lge_pkg::REG_EDIT_ENABLE: return {31'd0, cfg_edit};
      default:                  return '0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: the receiver cannot stall, so take every strobe as it comes
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    cell_readout_t want;
    if (rst_ni && $isunknown(result_valid_o)) begin
      $error("result_valid_o: expected 0 or 1, actual %b", result_valid_o);
      error_count++;
    end else if (rst_ni && result_valid_o) begin
      if (exp_count == 0) begin
        $error("unexpected read transaction: read_value %b outside_grid %b",
               read_value_o, outside_grid_o);
        error_count++;
      end else begin
        want   = exp_ring[exp_rd];
        exp_rd = (exp_rd + 1) % EXP_DEPTH;
        exp_count--;
        if (read_value_o !== want.read_value) begin
          $error("read_value: expected %b, actual %b", want.read_value, read_value_o);
          error_count++;
        end
        if (outside_grid_o !== want.outside_grid) begin
          $error("outside_grid: expected %b, actual %b", want.outside_grid, outside_grid_o);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------

  // Drop start, but only if it is still held: one assignment per time step
  task automatic stop_cmd();
    if (start_held) begin
      start      <= 1'b0;
      start_held  = 1'b0;
    end
  endtask

  task automatic idle_for(int cycles);
    stop_cmd();
    repeat (cycles) @(posedge clk_i);
  endtask

  // Present one command and hold it until the engine takes it. Start stays
  // high after it unless an idle gap follows, for back-to-back commands.
  task automatic send_cmd(logic [2:0] op, logic [5:0] col, logic [5:0] row, logic val);
    start         <= 1'b1;
    opcode_i      <= op;
    cell_col_i    <= col;
    cell_row_i    <= row;
    write_value_i <= val;
    start_held     = 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    apply_cmd(op, col, row, val);
    sent_cmds++;
    if (gaps_on && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 9));
  endtask

  // Hold off new commands until every read transaction has come back; always
  // let at least one edge pass so that start is not driven twice in one step
  task automatic drain_results();
    stop_cmd();
    do @(posedge clk_i); while (exp_count != 0);
  endtask

  // Steps and clears give no result: let one full sweep pass, then make sure
  // the engine is idle (this also covers the clearing pass after reset)
  task automatic settle_engine();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Configuration side
  // --------------------------------------------------------------------------
  task automatic apb_access(bit wr, logic [1:0] idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_register(logic [1:0] idx);
    logic [31:0] got;
    apb_access(1'b0, idx, '0, got);
    if (got !== reg_value(idx)) begin
      $error("prdata of register %0d: expected %h, actual %h", idx, reg_value(idx), got);
      error_count++;
    end
  endtask

  task automatic set_register(logic [1:0] idx, logic [31:0] value);
    logic [31:0] unused;
    apb_access(1'b1, idx, value, unused);
    case (idx)
      lge_pkg::REG_ACTIVE_COLS: cfg_cols = value[6:0];
      lge_pkg::REG_ACTIVE_ROWS: cfg_rows = value[6:0];
      lge_pkg::REG_EDIT_ENABLE: cfg_edit = value[0];
      default: ;
    endcase
    check_register(idx);
  endtask

  // Reprogram all registers once the engine is idle
  task automatic configure(logic [6:0] cols, logic [6:0] rows, logic edit);
    settle_engine();
    set_register(lge_pkg::REG_ACTIVE_COLS, {25'd0, cols});
    set_register(lge_pkg::REG_ACTIVE_ROWS, {25'd0, rows});
    set_register(lge_pkg::REG_EDIT_ENABLE, {31'd0, edit});
  endtask

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------

  // Favor the extremes: empty area, single line, full grid, oversized values
  function automatic logic [6:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return 7'd127;
      4:       return 7'($urandom_range(65, 127));
      5:       return 7'($urandom_range(2, 64));
      default: return 7'($urandom_range(2, 16));
    endcase
  endfunction

  // Mostly near the session's focus inside the area; now and then the border
  // index or anywhere in the field's range
  function automatic logic [5:0] pick_coord(int lim, int focus);
    int pos;
    if (lim == 0 || $urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
    if (lim < 64 && $urandom_range(0, 19) == 0) return 6'(lim);
    pos = focus + $urandom_range(0, 6) - 3;
    if (pos < 0) pos = 0;
    if (pos > lim - 1) pos = lim - 1;
    return 6'(pos);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values, reads at the grid corners, write with edit mode off,
  // rollback wrapping onto a never-written frame, unused opcodes
  task automatic test_reset_state();
    check_register(lge_pkg::REG_ACTIVE_COLS);
    check_register(lge_pkg::REG_ACTIVE_ROWS);
    check_register(lge_pkg::REG_EDIT_ENABLE);
    send_cmd(lge_pkg::OP_READ, 6'd0, 6'd0, 1'b0);
    send_cmd(lge_pkg::OP_READ, 6'd63, 6'd63, 1'b1);
    send_cmd(lge_pkg::OP_WRITE, 6'd1, 6'd1, 1'b1);
    send_cmd(lge_pkg::OP_READ, 6'd1, 6'd1, 1'b0);
    send_cmd(lge_pkg::OP_ROLLBACK, 6'd0, 6'd0, 1'b0);
    for (int o = int'(lge_pkg::OP_READ) + 1; o <= int'(OP_LAST); o++) begin
      send_cmd(3'(o), 6'd1, 6'd1, 1'b1);
    end
  endtask

  // Small area in edit mode: blinker against the left edge, writes at the
  // border index, one step, clear and rollback back to the stepped frame
  task automatic test_edit_border();
    configure(7'd5, 7'd4, 1'b1);
    send_cmd(lge_pkg::OP_WRITE, 6'd0, 6'd1, 1'b1);
    send_cmd(lge_pkg::OP_WRITE, 6'd1, 6'd1, 1'b1);
    send_cmd(lge_pkg::OP_WRITE, 6'd2, 6'd1, 1'b1);
    send_cmd(lge_pkg::OP_WRITE, 6'd5, 6'd1, 1'b1);
    send_cmd(lge_pkg::OP_WRITE, 6'd1, 6'd4, 1'b1);
    send_cmd(lge_pkg::OP_STEP, 6'd0, 6'd0, 1'b0);
    send_cmd(lge_pkg::OP_READ, 6'd1, 6'd0, 1'b0);
    send_cmd(lge_pkg::OP_READ, 6'd5, 6'd1, 1'b0);
    send_cmd(lge_pkg::OP_READ, 6'd0, 6'd1, 1'b0);
    send_cmd(lge_pkg::OP_CLEAR, 6'd0, 6'd0, 1'b0);
    send_cmd(lge_pkg::OP_READ, 6'd1, 6'd1, 1'b0);
    send_cmd(lge_pkg::OP_ROLLBACK, 6'd0, 6'd0, 1'b0);
    send_cmd(lge_pkg::OP_READ, 6'd1, 6'd1, 1'b0);
  endtask

  // Empty area: every access lies outside and a step leaves nothing alive;
  // then oversized registers clamp to the full grid
  task automatic test_zero_area();
    configure(7'd0, 7'd127, 1'b1);
    send_cmd(lge_pkg::OP_WRITE, 6'd0, 6'd0, 1'b1);
    send_cmd(lge_pkg::OP_READ, 6'd0, 6'd0, 1'b0);
    send_cmd(lge_pkg::OP_STEP, 6'd0, 6'd0, 1'b0);
    configure(7'd127, 7'd127, 1'b1);
    send_cmd(lge_pkg::OP_READ, 6'd63, 6'd63, 1'b0);
    send_cmd(lge_pkg::OP_READ, 6'd0, 6'd0, 1'b0);
  endtask

  // Sessions of edit/step/read traffic around a focus point, each with fresh
  // register settings; the last stretch runs without idle bursts
  task automatic test_random_sessions();
    int         base, sess_len, lim_c, lim_r, focus_c, focus_r, w;
    bit         calm;
    logic [2:0] op;
    logic [5:0] col, row;
    logic       val;
    base = sent_cmds;
    while (sent_cmds - base < RANDOM_ITEMS) begin
      configure(pick_size(), pick_size(), $urandom_range(0, 4) != 0);
      lim_c    = eff_size(cfg_cols, NCOLS);
      lim_r    = eff_size(cfg_rows, NROWS);
      focus_c  = (lim_c == 0) ? 0 : $urandom_range(0, lim_c - 1);
      focus_r  = (lim_r == 0) ? 0 : $urandom_range(0, lim_r - 1);
      calm     = ($urandom_range(0, 3) == 0);
      sess_len = $urandom_range(40, 80);
      for (int k = 0; k < sess_len; k++) begin
        gaps_on = !calm && (sent_cmds - base < RANDOM_ITEMS * 85 / 100);
        // Pause now and then until every read has come back
        if (k == sess_len / 2 && $urandom_range(0, 2) == 0) drain_results();
        w   = $urandom_range(0, 99);
        op  = lge_pkg::OP_STEP;
        col = 6'($urandom_range(0, 63));
        row = 6'($urandom_range(0, 63));
        val = 1'($urandom_range(0, 1));
        if (w < 34) begin
          op  = lge_pkg::OP_WRITE;
          col = pick_coord(lim_c, focus_c);
          row = pick_coord(lim_r, focus_r);
          val = ($urandom_range(0, 9) < 7);
        end else if (w < 60) begin
          op  = lge_pkg::OP_READ;
          col = pick_coord(lim_c, focus_c);
          row = pick_coord(lim_r, focus_r);
        end else if (w < 74) begin
          op = lge_pkg::OP_STEP;
        end else if (w < 79) begin
          op = lge_pkg::OP_CLEAR;
        end else if (w < 87) begin
          op = lge_pkg::OP_ROLLBACK;
        end else if (w < 91) begin
          op = 3'($urandom_range(int'(lge_pkg::OP_READ) + 1, int'(OP_LAST)));
        end else begin
          op = lge_pkg::OP_READ;
        end
        send_cmd(op, col, row, val);
      end
    end
    gaps_on = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset once, run the tests in turn, wait out the last results
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_edit_border();
    test_zero_area();
    test_random_sessions();
    settle_engine();
    if (error_count == 0 && exp_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
src/lge_pkg.sv
src/lge_cell.sv
src/lge_frame_mem.sv
src/life_grid_engine_with_history_core.sv
verif/tb.sv
